[design/vector_element_integer_alu_defines.svh]
// ----------------------------------------------------------------------------
// Vector element integer ALU: assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ELEMENT_INTEGER_ALU_DEFINES_SVH
`define VECTOR_ELEMENT_INTEGER_ALU_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define VEIA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VEIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/veia_pkg.sv]
// ----------------------------------------------------------------------------
// Vector element integer ALU: package
// Operation codes and the operation beat type shared by the ALU modules.
// ----------------------------------------------------------------------------
package veia_pkg;

    localparam int OPND_W = 64;
    localparam int FUNC_W = 4;
    localparam int WSEL_W = 2;

    // Operation codes; code 15 is unused and yields zero
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD = 4'd0,
        FN_SUB = 4'd1,
        FN_AND = 4'd2,
        FN_OR  = 4'd3,
        FN_XOR = 4'd4,
        FN_SLL = 4'd5,
        FN_SRL = 4'd6,
        FN_SRA = 4'd7,
        FN_EQ  = 4'd8,
        FN_NE  = 4'd9,
        FN_LT  = 4'd10,
        FN_LE  = 4'd11,
        FN_GT  = 4'd12,
        FN_GE  = 4'd13,
        FN_NEG = 4'd14
    } t_func;

    // One operation beat
    typedef struct packed {
        t_func             func;
        logic [OPND_W-1:0] operand_a;
        logic [OPND_W-1:0] operand_b;
    } t_op;

endpackage

[design/vector_element_integer_alu.sv]
// ----------------------------------------------------------------------------
// Vector element integer ALU: top level
// Input channel (i_valid / o_stall) carries func, operand_a and operand_b.
// Result channel (o_valid / i_stall) carries value and flag.
// A beat moves on a rising edge where valid is high and stall is low.
// The element width (8, 16, 32 or 64 bits, capped at MAX_BITS) is set by a
// write on the config channel (i_cfg_valid / o_cfg_ready); ready is high only
// while no beat is held anywhere in the block.
// Path: an accepted beat is held in the input register, then in the result
// register, which drives o_value/o_flag.
// Throughput: one beat per cycle while the receiver does not stall; the ALU is
// one combinational pass between the input register and the result register.
// When the receiver stalls, the result register holds; one further beat is
// caught in a skid register, after which o_stall rises (driven from a flop).
// Synchronous active-low reset empties all stages and sets the width to the
// largest supported value.
// ----------------------------------------------------------------------------
`include "vector_element_integer_alu_defines.svh"

module vector_element_integer_alu #(
    parameter int MAX_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [veia_pkg::WSEL_W-1:0] i_cfg_data,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [veia_pkg::FUNC_W-1:0] i_func,
    input  logic [veia_pkg::OPND_W-1:0] i_operand_a,
    input  logic [veia_pkg::OPND_W-1:0] i_operand_b,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [veia_pkg::OPND_W-1:0] o_value,
    output logic                        o_flag
);
    import veia_pkg::*;

    // widest width select the datapath supports: floor(log2(MAX_BITS / 8))
    localparam int MAX_SEL = $clog2(MAX_BITS / 8 + 1) - 1;

    logic [WSEL_W-1:0] r_width_sel;
    logic [WSEL_W-1:0] n_width_sel;
    t_op               in_op;
    t_op               s1_op;
    logic              s1_valid;
    logic              advance;
    logic [OPND_W-1:0] alu_value;
    logic              alu_flag;
    logic              r_out_valid;
    logic [OPND_W-1:0] r_value;
    logic              r_flag;
    logic [OPND_W-1:0] width_mask;

    // width register, clamped to what the datapath carries
    assign n_width_sel = (32'(i_cfg_data) > MAX_SEL) ? WSEL_W'(MAX_SEL) : i_cfg_data;
    assign o_cfg_ready = !(s1_valid || r_out_valid || o_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_sel <= WSEL_W'(MAX_SEL);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_width_sel <= n_width_sel;
        end
    end

    // input register with skid
    always_comb begin
        in_op.func      = t_func'(i_func);
        in_op.operand_a = i_operand_a;
        in_op.operand_b = i_operand_b;
    end

    veia_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_op      (in_op),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_op      (s1_op)
    );

    // single-pass datapath
    veia_alu #(
        .DW (MAX_BITS)
    ) u_alu (
        .i_width_sel (r_width_sel),
        .i_op        (s1_op),
        .o_value     (alu_value),
        .o_flag      (alu_flag)
    );

    // result register: loads when empty or when its beat is taken
    assign advance = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_value <= alu_value;
            r_flag  <= alu_flag;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_value;
    assign o_flag  = r_flag;

    // mask of the current element width, for checking only
    always_comb begin
        for (int i = 0; i < OPND_W; i++) begin
            width_mask[i] = (i < (8 << r_width_sel));
        end
    end

    // checks
    `VEIA_ASSERT_NOW(a_skid_needs_blocked_out, i_clk, i_rst_n, o_stall, o_valid, "skid full while result register empty")
    `VEIA_ASSERT_NOW(a_flag_means_one, i_clk, i_rst_n, o_valid && o_flag, o_value == 64'd1, "compare flag set but value is not one")
    `VEIA_ASSERT_NOW(a_upper_bits_zero, i_clk, i_rst_n, o_valid, (o_value & ~width_mask) == '0, "result bits above element width")
    `VEIA_ASSERT_NEXT(a_skid_from_stall, i_clk, i_rst_n, !o_stall && !(o_valid && i_stall), !o_stall, "skid filled while result register was moving")

endmodule

[design/veia_in_stage.sv]
// ----------------------------------------------------------------------------
// Vector element integer ALU: input stage
// Input register with a one-beat skid so that stall is driven from a flop.
// ----------------------------------------------------------------------------
module veia_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  veia_pkg::t_op  i_op,
    input  logic           i_advance,
    output logic           o_valid,
    output veia_pkg::t_op  o_op
);
    import veia_pkg::*;

    logic r_s1_valid;
    logic n_s1_valid;
    t_op  r_s1_op;
    logic r_skid_valid;
    logic n_skid_valid;
    t_op  r_skid_op;
    logic accept;
    logic s1_load;

    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;
    // stage register can take a beat when empty or when it moves on
    assign s1_load = i_advance || !r_s1_valid;

    // next-state for the valid flags
    always_comb begin
        n_s1_valid   = r_s1_valid;
        n_skid_valid = r_skid_valid;
        if (s1_load) begin
            n_s1_valid   = r_skid_valid || accept;
            n_skid_valid = 1'b0;
        end else if (accept) begin
            n_skid_valid = 1'b1;
        end
    end

    // control flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_s1_valid   <= n_s1_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload flops, skid drains first to keep order
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_op <= r_skid_valid ? r_skid_op : i_op;
        end
        if (!s1_load && accept) begin
            r_skid_op <= i_op;
        end
    end

    assign o_valid = r_s1_valid;
    assign o_op    = r_s1_op;

endmodule

[design/veia_alu.sv]
// ----------------------------------------------------------------------------
// Vector element integer ALU: datapath
// Single-pass arithmetic, logic, shift and compare on one element.
// ----------------------------------------------------------------------------
module veia_alu #(
    parameter int DW = 64
) (
    input  logic [veia_pkg::WSEL_W-1:0] i_width_sel,
    input  veia_pkg::t_op               i_op,
    output logic [veia_pkg::OPND_W-1:0] o_value,
    output logic                        o_flag
);
    import veia_pkg::*;

    localparam int SW = (DW > 1) ? $clog2(DW) : 1;

    logic [DW-1:0]        mask;
    logic [DW-1:0]        msb_sel;
    logic [SW-1:0]        sh_mask;
    logic [DW-1:0]        a;
    logic [DW-1:0]        b;
    logic [SW-1:0]        sh;
    logic [DW-1:0]        a_sx;
    logic signed [DW-1:0] sra_v;
    logic                 lt_ab;
    logic                 lt_ba;
    logic [DW-1:0]        res;
    logic                 cmp;
    logic                 is_cmp;

    // element mask, sign position and shift-amount mask for the width
    always_comb begin
        for (int i = 0; i < DW; i++) begin
            mask[i]    = (i < (8 << i_width_sel));
            msb_sel[i] = (i == ((8 << i_width_sel) - 1));
        end
        for (int j = 0; j < SW; j++) begin
            sh_mask[j] = (j < (32'(i_width_sel) + 3));
        end
    end

    assign a  = i_op.operand_a[DW-1:0] & mask;
    assign b  = i_op.operand_b[DW-1:0] & mask;
    assign sh = b[SW-1:0] & sh_mask;

    // sign-extend the element to the datapath width for the arithmetic shift
    assign a_sx  = a | ((|(a & msb_sel)) ? ~mask : '0);
    assign sra_v = $signed(a_sx) >>> sh;

    // signed compare: flip the sign bit, then compare unsigned
    assign lt_ab = (a ^ msb_sel) < (b ^ msb_sel);
    assign lt_ba = (b ^ msb_sel) < (a ^ msb_sel);

    // operation select
    always_comb begin
        res    = '0;
        cmp    = 1'b0;
        is_cmp = 1'b0;
        case (i_op.func)
            FN_ADD: res = a + b;
            FN_SUB: res = a - b;
            FN_AND: res = a & b;
            FN_OR:  res = a | b;
            FN_XOR: res = a ^ b;
            FN_SLL: res = a << sh;
            FN_SRL: res = a >> sh;
            FN_SRA: res = sra_v;
            FN_EQ: begin
                is_cmp = 1'b1;
                cmp    = (a == b);
            end
            FN_NE: begin
                is_cmp = 1'b1;
                cmp    = (a != b);
            end
            FN_LT: begin
                is_cmp = 1'b1;
                cmp    = lt_ab;
            end
            FN_LE: begin
                is_cmp = 1'b1;
                cmp    = !lt_ba;
            end
            FN_GT: begin
                is_cmp = 1'b1;
                cmp    = lt_ba;
            end
            FN_GE: begin
                is_cmp = 1'b1;
                cmp    = !lt_ab;
            end
            FN_NEG:  res = '0 - a;
            default: res = '0;
        endcase
        if (is_cmp) begin
            res = {{(DW-1){1'b0}}, cmp};
        end
    end

    assign o_value = OPND_W'(res & mask);
    assign o_flag  = is_cmp && cmp;

endmodule
